@@ sv/sbcf_pkg.sv @@
// Shared types and constants for the servo bus command framer.
`timescale 1ns / 1ps

package sbcf_pkg;

  localparam logic [7:0] HDR_BYTE    = 8'hFF;
  localparam logic [7:0] INSTR_PING  = 8'h01;
  localparam logic [7:0] INSTR_READ  = 8'h02;
  localparam logic [7:0] INSTR_WRITE = 8'h03;
  localparam logic [7:0] PING_LEN    = 8'h02;
  localparam logic [7:0] READ_LEN    = 8'h04;
  localparam logic [7:0] WRITE1_LEN  = 8'h04;
  localparam logic [7:0] WRITE2_LEN  = 8'h05;

  // Body is id, length, instruction and up to three parameters.
  localparam int BODY_MAX = 6;
  localparam int BODY_IW  = $clog2(BODY_MAX);
  localparam int NBODY_W  = $clog2(BODY_MAX + 1);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [NBODY_W-1:0] NBODY_PING   = NBODY_W'(3);
  localparam logic [NBODY_W-1:0] NBODY_READ   = NBODY_W'(5);
  localparam logic [NBODY_W-1:0] NBODY_WRITE1 = NBODY_W'(5);
  localparam logic [NBODY_W-1:0] NBODY_WRITE2 = NBODY_W'(6);

  typedef enum logic [1:0] {
    ACT_PING  = 2'd0,
    ACT_READ  = 2'd1,
    ACT_WRITE = 2'd2,
    ACT_NONE  = 2'd3
  } sbcf_action_t;

  // One classified command, ready to be serialized.
  typedef struct packed {
    logic [BODY_MAX-1:0][7:0] body;
    logic [NBODY_W-1:0]       nbody;
    logic [7:0]               chk;
  } sbcf_cmd_t;

endpackage

@@ sv/sbcf_front.sv @@
// Front end: accepts command words, builds the packet body and checksum.
`timescale 1ns / 1ps

module sbcf_front (
  input  logic                    in_tvalid,
  output logic                    in_tready,
  input  logic [47:0]             in_tdata,
  input  logic [1:0]              in_tuser,
  input  logic                    q_full,
  output logic                    q_push,
  output sbcf_pkg::sbcf_cmd_t     q_cmd
);

  sbcf_pkg::sbcf_action_t act;
  logic [7:0]  dev_id;
  logic [7:0]  start_address;
  logic [7:0]  read_count;
  logic [15:0] write_data;
  logic [1:0]  write_count;
  logic [7:0]  sum;

  assign act           = sbcf_pkg::sbcf_action_t'(in_tuser);
  assign dev_id        = in_tdata[7:0];
  assign start_address = in_tdata[15:8];
  assign read_count    = in_tdata[23:16];
  assign write_data    = in_tdata[39:24];
  assign write_count   = in_tdata[41:40];

  assign in_tready = !q_full;
  // An unused action code is taken and dropped.
  assign q_push    = in_tvalid && !q_full && (act != sbcf_pkg::ACT_NONE);

  always_comb begin
    q_cmd.body    = '0;
    q_cmd.body[0] = dev_id;
    q_cmd.nbody   = sbcf_pkg::NBODY_PING;
    unique case (act)
      sbcf_pkg::ACT_PING: begin
        q_cmd.body[1] = sbcf_pkg::PING_LEN;
        q_cmd.body[2] = sbcf_pkg::INSTR_PING;
        q_cmd.nbody   = sbcf_pkg::NBODY_PING;
      end
      sbcf_pkg::ACT_READ: begin
        q_cmd.body[1] = sbcf_pkg::READ_LEN;
        q_cmd.body[2] = sbcf_pkg::INSTR_READ;
        q_cmd.body[3] = start_address;
        q_cmd.body[4] = read_count;
        q_cmd.nbody   = sbcf_pkg::NBODY_READ;
      end
      default: begin
        q_cmd.body[2] = sbcf_pkg::INSTR_WRITE;
        q_cmd.body[3] = start_address;
        // A count of zero sends one byte and a count of three sends two.
        if (write_count[1]) begin
          q_cmd.body[1] = sbcf_pkg::WRITE2_LEN;
          q_cmd.body[4] = write_data[15:8];
          q_cmd.body[5] = write_data[7:0];
          q_cmd.nbody   = sbcf_pkg::NBODY_WRITE2;
        end else begin
          q_cmd.body[1] = sbcf_pkg::WRITE1_LEN;
          q_cmd.body[4] = write_data[7:0];
          q_cmd.nbody   = sbcf_pkg::NBODY_WRITE1;
        end
      end
    endcase
    // Unused body bytes are zero, so they drop out of the sum.
    sum = q_cmd.body[0] + q_cmd.body[1] + q_cmd.body[2] +
          q_cmd.body[3] + q_cmd.body[4] + q_cmd.body[5];
    q_cmd.chk = ~sum;
  end

endmodule

@@ sv/sbcf_queue.sv @@
// Short command queue between the front end and the byte serializer.
`timescale 1ns / 1ps

module sbcf_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  sbcf_pkg::sbcf_cmd_t push_cmd,
  output logic                full,
  input  logic                pop,
  output logic                head_valid,
  output sbcf_pkg::sbcf_cmd_t head_cmd
);

  sbcf_pkg::sbcf_cmd_t mem [sbcf_pkg::QUEUE_DEPTH];

  logic [sbcf_pkg::QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [sbcf_pkg::QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [sbcf_pkg::QCNT_W-1:0] cnt_r, cnt_nxt;

  assign full       = (cnt_r == sbcf_pkg::QCNT_W'(sbcf_pkg::QUEUE_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_cmd   = mem[rd_ptr_r];

  function automatic logic [sbcf_pkg::QPTR_W-1:0] ptr_inc(
    input logic [sbcf_pkg::QPTR_W-1:0] p
  );
    if (p == sbcf_pkg::QPTR_W'(sbcf_pkg::QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_cmd;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("queue popped while empty");

  a_cnt_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= sbcf_pkg::QCNT_W'(sbcf_pkg::QUEUE_DEPTH))
    else $error("queue count above depth");

endmodule

@@ sv/sbcf_back.sv @@
// Back end: walks the head command and sends its packet one byte per word.
`timescale 1ns / 1ps

module sbcf_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                head_valid,
  input  sbcf_pkg::sbcf_cmd_t head_cmd,
  output logic                pop,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [7:0]          out_tdata,
  output logic                out_tlast
);

  // Byte index within the packet: two header bytes, body, checksum.
  logic [3:0] idx_r, idx_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_data_r, out_data_nxt;
  logic       out_last_r, out_last_nxt;

  logic                         load;
  logic [3:0]                   chk_idx;
  logic [sbcf_pkg::BODY_IW-1:0] sel;
  logic [7:0]                   cur_byte;
  logic                         cur_last;

  assign load    = !out_valid_r || out_tready;
  assign chk_idx = 4'(head_cmd.nbody) + 4'd2;
  assign sel     = sbcf_pkg::BODY_IW'(idx_r - 4'd2);

  always_comb begin
    cur_last = 1'b0;
    if (idx_r < 4'd2) begin
      cur_byte = sbcf_pkg::HDR_BYTE;
    end else if (idx_r == chk_idx) begin
      cur_byte = head_cmd.chk;
      cur_last = 1'b1;
    end else begin
      cur_byte = head_cmd.body[sel];
    end
  end

  always_comb begin
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    pop           = 1'b0;
    if (load) begin
      out_valid_nxt = head_valid;
      if (head_valid) begin
        out_data_nxt = cur_byte;
        out_last_nxt = cur_last;
        if (cur_last) begin
          idx_nxt = '0;
          pop     = 1'b1;
        end else begin
          idx_nxt = idx_r + 4'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  a_idx_in_packet: assert property (@(posedge clk) disable iff (!rst_n)
    head_valid |-> idx_r <= chk_idx)
    else $error("byte index ran past the checksum");

  a_idle_idx_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !head_valid |-> idx_r == '0)
    else $error("byte index left mid-packet with no command");

  a_pop_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> out_tvalid && out_tlast && out_tdata == $past(head_cmd.chk))
    else $error("command retired without sending its checksum");

endmodule

@@ sv/servo_bus_command_framer.sv @@
// Top level of the servo bus command framer.
// Usage: each word on the in_ channel is one servo command (ping, read or
// write), with the command kind in in_tuser and its operands in in_tdata.
// The block sends the matching instruction packet on the out_ channel, one
// byte per word: 0xFF 0xFF, id, length, instruction, parameters, checksum,
// with out_tlast high on the checksum byte. Ping gives 6 bytes, read 8 and
// write 8 or 9. A command with the unused kind code is taken and dropped.
// A taken command word is written into the queue and, if the serializer is
// free, its first byte is then loaded into the output register. Throughput:
// one byte per cycle while the receiver does not stall, and packets follow
// each other with no gap; the byte serializer sets this rate. A two-entry
// command queue lets in_tready stay high while an earlier packet is still
// going out; in_tready drops only when the queue is full.
// When the receiver stalls, the output register holds its byte and the
// serializer stops; commands keep being taken until the queue fills.
// Reset (rst_n low, synchronous) empties the queue and clears out_tvalid.
`timescale 1ns / 1ps

module servo_bus_command_framer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // Fields from bit 0: dev_id[7:0], start_address[15:8], read_count[23:16],
  // write_data[39:24], write_count[41:40], zero fill[47:42].
  input  logic [47:0] in_tdata,
  // Fields from bit 0: action[1:0].
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // Fields from bit 0: tx_byte[7:0].
  output logic [7:0]  out_tdata,
  output logic        out_tlast
);

  logic                q_full;
  logic                q_push;
  logic                q_pop;
  logic                head_valid;
  sbcf_pkg::sbcf_cmd_t push_cmd;
  sbcf_pkg::sbcf_cmd_t head_cmd;

  sbcf_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (push_cmd)
  );

  sbcf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  sbcf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

@@ test/testbench.sv @@
// Self-checking testbench for the servo bus command framer, with its own packet predictor.
`timescale 1ns / 1ps

module testbench;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } pkt_byte_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  // Fields from bit 0: dev_id[7:0], start_address[15:8], read_count[23:16],
  // write_data[39:24], write_count[41:40], zero fill[47:42].
  logic [47:0] in_tdata;
  // Fields from bit 0: action[1:0].
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  // Fields from bit 0: tx_byte[7:0].
  logic [7:0]  out_tdata;
  logic        out_tlast;

  pkt_byte_t expected_bytes[$];
  int        error_count;
  int        send_idle_pct;
  int        recv_stall_pct;

  servo_bus_command_framer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  task automatic report_mismatch(input string msg);
    if (error_count < 20) begin
      $display("MISMATCH at %0t: %s", $realtime, msg);
    end
    error_count++;
  endtask

  // Builds the instruction packet of one command and queues its bytes.
  function automatic void frame_command(input sbcf_pkg::sbcf_action_t act,
                                        input logic [7:0] id,
                                        input logic [7:0] addr, input logic [7:0] rcount,
                                        input logic [15:0] wdata, input logic [1:0] wcount);
    logic [7:0] body[$];
    logic [7:0] sum;
    sum = 8'h00;
    if (act == sbcf_pkg::ACT_NONE) begin
      return;
    end
    body.push_back(id);
    case (act)
      sbcf_pkg::ACT_PING: begin
        body.push_back(sbcf_pkg::PING_LEN);
        body.push_back(sbcf_pkg::INSTR_PING);
      end
      sbcf_pkg::ACT_READ: begin
        body.push_back(sbcf_pkg::READ_LEN);
        body.push_back(sbcf_pkg::INSTR_READ);
        body.push_back(addr);
        body.push_back(rcount);
      end
      default: begin
        // A count of zero sends one byte and a count of three sends two.
        body.push_back((wcount >= 2'd2) ? sbcf_pkg::WRITE2_LEN : sbcf_pkg::WRITE1_LEN);
        body.push_back(sbcf_pkg::INSTR_WRITE);
        body.push_back(addr);
        if (wcount >= 2'd2) begin
          body.push_back(wdata[15:8]);
        end
        body.push_back(wdata[7:0]);
      end
    endcase
    expected_bytes.push_back('{sbcf_pkg::HDR_BYTE, 1'b0});
    expected_bytes.push_back('{sbcf_pkg::HDR_BYTE, 1'b0});
    foreach (body[i]) begin
      sum += body[i];
      expected_bytes.push_back('{body[i], 1'b0});
    end
    expected_bytes.push_back('{~sum, 1'b1});
  endfunction

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic send_command(input sbcf_pkg::sbcf_action_t act, input logic [7:0] id,
                              input logic [7:0] addr, input logic [7:0] rcount,
                              input logic [15:0] wdata, input logic [1:0] wcount);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = act;
    in_tdata  = {6'b0, wcount, wdata, rcount, addr, id};
    do begin
      @(posedge clk);
    end while (!in_tready);
    frame_command(act, id, addr, rcount, wdata, wcount);
    @(negedge clk);
  endtask

  task automatic send_random_command();
    sbcf_pkg::sbcf_action_t act;
    if ($urandom_range(99) < 5) begin
      act = sbcf_pkg::ACT_NONE;
    end else begin
      act = sbcf_pkg::sbcf_action_t'($urandom_range(2));
    end
    send_command(act, 8'($urandom), 8'($urandom), 8'($urandom), 16'($urandom),
                 2'($urandom_range(3)));
  endtask

  task automatic test_field_extremes();
    send_command(sbcf_pkg::ACT_PING, 8'h00, 8'h00, 8'h00, 16'h0000, 2'd0);
    send_command(sbcf_pkg::ACT_PING, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 2'd3);
    send_command(sbcf_pkg::ACT_PING, 8'hFE, 8'h5A, 8'hA5, 16'h1234, 2'd2);
    send_command(sbcf_pkg::ACT_READ, 8'h00, 8'h00, 8'h00, 16'hFFFF, 2'd3);
    send_command(sbcf_pkg::ACT_READ, 8'hFF, 8'hFF, 8'hFF, 16'h0000, 2'd0);
    send_command(sbcf_pkg::ACT_READ, 8'h01, 8'h24, 8'h02, 16'hA5A5, 2'd1);
    send_command(sbcf_pkg::ACT_WRITE, 8'h00, 8'h00, 8'hFF, 16'h0000, 2'd2);
    send_command(sbcf_pkg::ACT_WRITE, 8'hFF, 8'hFF, 8'h00, 16'hFFFF, 2'd2);
    send_command(sbcf_pkg::ACT_WRITE, 8'hFF, 8'hFF, 8'h00, 16'hFFFF, 2'd1);
  endtask

  task automatic test_write_counts();
    send_command(sbcf_pkg::ACT_WRITE, 8'h05, 8'h1E, 8'h00, 16'hFF00, 2'd0);
    send_command(sbcf_pkg::ACT_WRITE, 8'h05, 8'h1E, 8'h00, 16'h00FF, 2'd0);
    send_command(sbcf_pkg::ACT_WRITE, 8'h06, 8'h20, 8'h00, 16'h00FF, 2'd1);
    send_command(sbcf_pkg::ACT_WRITE, 8'h07, 8'h2A, 8'h00, 16'hFF00, 2'd2);
    send_command(sbcf_pkg::ACT_WRITE, 8'h08, 8'h2E, 8'h00, 16'h00FF, 2'd3);
    send_command(sbcf_pkg::ACT_WRITE, 8'h09, 8'h30, 8'h00, 16'hBEEF, 2'd3);
  endtask

  // The unused kind code must be taken and dropped without any output.
  task automatic test_unused_action();
    send_command(sbcf_pkg::ACT_NONE, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 2'd3);
    send_command(sbcf_pkg::ACT_PING, 8'h10, 8'h00, 8'h00, 16'h0000, 2'd0);
    send_command(sbcf_pkg::ACT_NONE, 8'h00, 8'h00, 8'h00, 16'h0000, 2'd0);
    send_command(sbcf_pkg::ACT_NONE, 8'h3C, 8'hC3, 8'h99, 16'h6666, 2'd1);
    send_command(sbcf_pkg::ACT_READ, 8'h11, 8'h38, 8'h02, 16'h0000, 2'd0);
  endtask

  task automatic test_random_traffic(input int per_phase);
    int sender_pct[4];
    int receiver_pct[4];
    sender_pct   = '{0, 70, 0, 26};
    receiver_pct = '{0, 0, 70, 26};
    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct  = sender_pct[phase];
      recv_stall_pct = receiver_pct[phase];
      for (int n = 0; n < per_phase; n++) begin
        send_random_command();
      end
    end
    send_idle_pct  = 0;
    recv_stall_pct = 0;
  endtask

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin : check_bytes
    pkt_byte_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_bytes.size() == 0) begin
        report_mismatch($sformatf("unexpected byte %02h last %0b", out_tdata, out_tlast));
      end else begin
        want = expected_bytes.pop_front();
        if (out_tdata !== want.value) begin
          report_mismatch($sformatf("tx_byte %02h, want %02h", out_tdata, want.value));
        end
        if (out_tlast !== want.last) begin
          report_mismatch($sformatf("last_byte %0b, want %0b", out_tlast, want.last));
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    in_tuser       = '0;
    out_tready     = 1'b0;
    error_count    = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_field_extremes();
    test_write_counts();
    test_unused_action();
    test_random_traffic(38);

    in_tvalid = 1'b0;
    while (expected_bytes.size() != 0) begin
      @(posedge clk);
    end
    // A stray packet would show up within this window; a dropped command stalls the wait above until the timeout.
    repeat (30) @(posedge clk);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
